[design/fsp_pkg.sv]
// Shared types and character codes for the format specifier parser.
package fsp_pkg;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_L     = 8'h6c;
   localparam logic [7:0] CH_H     = 8'h68;
   localparam logic [7:0] CH_J     = 8'h6a;
   localparam logic [7:0] CH_Z     = 8'h7a;

   typedef enum logic [2:0] {
      LEN_NONE = 3'd0,
      LEN_L    = 3'd1,
      LEN_LL   = 3'd2,
      LEN_H    = 3'd3,
      LEN_HH   = 3'd4,
      LEN_J    = 3'd5,
      LEN_Z    = 3'd6
   } length_type;

   typedef enum logic [5:0] {
      PH_FLAGS   = 6'b000001,
      PH_WIDTH   = 6'b000010,
      PH_PREC    = 6'b000100,
      PH_AFTER_L = 6'b001000,
      PH_AFTER_H = 6'b010000,
      PH_CONV    = 6'b100000
   } phase_type;

   typedef struct packed {
      logic plus_flag;
      logic space_flag;
      logic left_flag;
      logic alternate_flag;
      logic zero_flag;
   } flags_type;

   typedef struct packed {
      logic [7:0]  conversion;
      logic        plus_flag;
      logic        space_flag;
      logic        left_flag;
      logic        alternate_flag;
      logic        zero_pad_flag;
      logic [15:0] field_width;
      logic        has_precision;
      logic [15:0] precision_value;
      length_type  length_code;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] ch;
   } byte_type;

endpackage

[design/fsp_in_stage.sv]
// Input register holding one format byte for the parser.
module fsp_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_ch,
   input  logic              take,
   output fsp_pkg::byte_type byte_out
);

   logic       valid_ff, valid_in;
   logic [7:0] ch_ff;

   assign req_ready = !valid_ff || take;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         ch_ff <= req_ch;
      end
   end

   assign byte_out.valid = valid_ff;
   assign byte_out.ch    = ch_ff;

endmodule

[design/fsp_parser.sv]
// Specifier state, per-byte step logic and result register.
module fsp_parser #(
   parameter int NUMBER_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  fsp_pkg::byte_type   byte_in,
   output logic                take,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fsp_pkg::result_type rsp_data
);

   localparam int ACC_BITS = NUMBER_BITS + 4;

   fsp_pkg::phase_type  phase_ff, phase_in;
   fsp_pkg::flags_type  flags_ff, flags_in;
   fsp_pkg::length_type length_ff, length_in;
   logic [NUMBER_BITS-1:0] width_ff, width_in;
   logic [NUMBER_BITS-1:0] prec_ff, prec_in;
   logic                   dot_ff, dot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   fsp_pkg::result_type    rsp_data_ff, result;

   logic [7:0]             ch;
   logic                   digit, emit, do_len;
   logic [3:0]             digit_val;
   logic [NUMBER_BITS+15:0] width_ext, prec_ext;

   function automatic logic [NUMBER_BITS-1:0] accumulate(
      input logic [NUMBER_BITS-1:0] acc,
      input logic [3:0]             d
   );
      logic [ACC_BITS-1:0] v;
      v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{NUMBER_BITS{1'b0}}, d};
      if (v > {4'b0, {NUMBER_BITS{1'b1}}}) begin
         return {NUMBER_BITS{1'b1}};
      end
      return v[NUMBER_BITS-1:0];
   endfunction

   assign ch        = byte_in.ch;
   assign digit     = (ch >= fsp_pkg::CH_ZERO) && (ch <= fsp_pkg::CH_NINE);
   assign digit_val = 4'(ch - fsp_pkg::CH_ZERO);
   assign take      = byte_in.valid && (!rsp_valid_ff || rsp_ready);

   assign width_ext = {16'b0, width_ff};
   assign prec_ext  = {16'b0, prec_ff};

   always_comb begin
      result.conversion      = ch;
      result.plus_flag       = flags_ff.plus_flag;
      result.space_flag      = flags_ff.space_flag;
      result.left_flag       = flags_ff.left_flag;
      result.alternate_flag  = flags_ff.alternate_flag;
      result.zero_pad_flag   = flags_ff.zero_flag && !flags_ff.left_flag;
      result.field_width     = width_ext[15:0];
      result.has_precision   = dot_ff;
      result.precision_value = prec_ext[15:0];
      result.length_code     = length_ff;
   end

   always_comb begin
      phase_in  = phase_ff;
      flags_in  = flags_ff;
      length_in = length_ff;
      width_in  = width_ff;
      prec_in   = prec_ff;
      dot_in    = dot_ff;
      emit      = 1'b0;
      do_len    = 1'b0;
      if (ch == fsp_pkg::CH_NUL) begin
         emit = 1'b1;
      end else begin
         case (phase_ff)
            fsp_pkg::PH_WIDTH: begin
               if (digit) begin
                  width_in = accumulate(width_ff, digit_val);
               end else if (ch == fsp_pkg::CH_DOT) begin
                  dot_in   = 1'b1;
                  prec_in  = '0;
                  phase_in = fsp_pkg::PH_PREC;
               end else begin
                  do_len = 1'b1;
               end
            end
            fsp_pkg::PH_PREC: begin
               if (digit) begin
                  prec_in = accumulate(prec_ff, digit_val);
               end else begin
                  do_len = 1'b1;
               end
            end
            fsp_pkg::PH_AFTER_L: begin
               if (ch == fsp_pkg::CH_L) begin
                  length_in = fsp_pkg::LEN_LL;
                  phase_in  = fsp_pkg::PH_CONV;
               end else begin
                  emit = 1'b1;
               end
            end
            fsp_pkg::PH_AFTER_H: begin
               if (ch == fsp_pkg::CH_H) begin
                  length_in = fsp_pkg::LEN_HH;
                  phase_in  = fsp_pkg::PH_CONV;
               end else begin
                  emit = 1'b1;
               end
            end
            fsp_pkg::PH_CONV: begin
               emit = 1'b1;
            end
            default: begin
               if (ch == fsp_pkg::CH_PLUS) begin
                  flags_in.plus_flag = 1'b1;
               end else if (ch == fsp_pkg::CH_SPACE) begin
                  flags_in.space_flag = 1'b1;
               end else if (ch == fsp_pkg::CH_MINUS) begin
                  flags_in.left_flag = 1'b1;
               end else if (ch == fsp_pkg::CH_HASH) begin
                  flags_in.alternate_flag = 1'b1;
               end else if (ch == fsp_pkg::CH_ZERO) begin
                  flags_in.zero_flag = 1'b1;
               end else if (digit) begin
                  width_in = NUMBER_BITS'(digit_val);
                  phase_in = fsp_pkg::PH_WIDTH;
               end else if (ch == fsp_pkg::CH_DOT) begin
                  dot_in   = 1'b1;
                  prec_in  = '0;
                  phase_in = fsp_pkg::PH_PREC;
               end else begin
                  do_len = 1'b1;
               end
            end
         endcase
         if (do_len) begin
            if (ch == fsp_pkg::CH_L) begin
               length_in = fsp_pkg::LEN_L;
               phase_in  = fsp_pkg::PH_AFTER_L;
            end else if (ch == fsp_pkg::CH_H) begin
               length_in = fsp_pkg::LEN_H;
               phase_in  = fsp_pkg::PH_AFTER_H;
            end else if (ch == fsp_pkg::CH_J) begin
               length_in = fsp_pkg::LEN_J;
               phase_in  = fsp_pkg::PH_CONV;
            end else if (ch == fsp_pkg::CH_Z) begin
               length_in = fsp_pkg::LEN_Z;
               phase_in  = fsp_pkg::PH_CONV;
            end else begin
               emit = 1'b1;
            end
         end
      end
      if (emit) begin
         phase_in  = fsp_pkg::PH_FLAGS;
         flags_in  = '0;
         length_in = fsp_pkg::LEN_NONE;
         width_in  = '0;
         prec_in   = '0;
         dot_in    = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= fsp_pkg::PH_FLAGS;
         flags_ff     <= '0;
         length_ff    <= fsp_pkg::LEN_NONE;
         width_ff     <= '0;
         prec_ff      <= '0;
         dot_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff  <= phase_in;
            flags_ff  <= flags_in;
            length_ff <= length_in;
            width_ff  <= width_in;
            prec_ff   <= prec_in;
            dot_ff    <= dot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/format_specifier_parser_top.sv]
// Top level of the printf format specifier parser.
//
// Input channel req_: one format byte per transaction (req_ch), the bytes
// that follow a percent sign. Result channel rsp_: one transaction per
// specifier, carrying the conversion byte, the five flags, width,
// precision and length modifier code.
// A byte is held in an input register and stepped through the parser from
// there; the result register is loaded when the parser takes the
// conversion byte (or a zero byte), and rsp_valid rises as it is loaded.
// Throughput is one byte per cycle while no result waits with rsp_ready
// low; each byte steps the parser state and the multiply-by-ten accumulate
// of width or precision.
// While a result waits with rsp_ready low the parser steps no byte: the
// input register accepts one more byte and req_ready then stays low until
// the result is taken.
// Synchronous reset returns the parser to the flags phase and empties both
// registers. Width and precision saturate at 2**NUMBER_BITS - 1 and are
// reported in 16 bits.
module format_specifier_parser_top #(
   parameter int NUMBER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_conversion,
   output logic        rsp_plus_flag,
   output logic        rsp_space_flag,
   output logic        rsp_left_flag,
   output logic        rsp_alternate_flag,
   output logic        rsp_zero_pad_flag,
   output logic [15:0] rsp_field_width,
   output logic        rsp_has_precision,
   output logic [15:0] rsp_precision_value,
   output logic [2:0]  rsp_length_code
);

   fsp_pkg::byte_type   in_byte;
   fsp_pkg::result_type rsp_data;
   logic                take;

   fsp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_ch    (req_ch),
      .take      (take),
      .byte_out  (in_byte)
   );

   fsp_parser #(
      .NUMBER_BITS (NUMBER_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_in   (in_byte),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_conversion      = rsp_data.conversion;
   assign rsp_plus_flag       = rsp_data.plus_flag;
   assign rsp_space_flag      = rsp_data.space_flag;
   assign rsp_left_flag       = rsp_data.left_flag;
   assign rsp_alternate_flag  = rsp_data.alternate_flag;
   assign rsp_zero_pad_flag   = rsp_data.zero_pad_flag;
   assign rsp_field_width     = rsp_data.field_width;
   assign rsp_has_precision   = rsp_data.has_precision;
   assign rsp_precision_value = rsp_data.precision_value;
   assign rsp_length_code     = rsp_data.length_code;

`ifndef SYNTHESIS
   a_zero_pad_vs_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_left_flag && rsp_zero_pad_flag))
      else $error("zero pad reported together with left justify");

   a_no_prec_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_precision) |-> (rsp_precision_value == 16'd0))
      else $error("precision value without a dot");

   a_take_needs_room: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && in_byte.valid) |=> rsp_valid)
      else $error("pending result dropped while stalled");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("registers not empty after reset");
`endif

endmodule

[verif/tb.sv]
// Testbench for the format specifier parser: predicts and checks every specifier.
`timescale 1ns / 100ps

module tb;

   localparam int NUM_BITS = 16;
   localparam int RANDOM_ITEMS = 700;
   localparam int TAIL_CYCLES = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int REPORT_LIMIT = 10;
   localparam logic [39:0] FLAG_CHARS = {fsp_pkg::CH_PLUS, fsp_pkg::CH_SPACE,
                                         fsp_pkg::CH_MINUS, fsp_pkg::CH_HASH,
                                         fsp_pkg::CH_ZERO};

   class specifier_tracker;
      fsp_pkg::phase_type   phase;
      fsp_pkg::flags_type   flags;
      logic [31:0]          width_acc;
      logic [31:0]          prec_acc;
      logic                 dot_seen;
      fsp_pkg::length_type  length;
      fsp_pkg::result_type  expected_specs[$];
      int                   failures;

      function new();
         failures = 0;
         clear_state();
      endfunction

      function void clear_state();
         phase     = fsp_pkg::PH_FLAGS;
         flags     = '0;
         width_acc = '0;
         prec_acc  = '0;
         dot_seen  = 1'b0;
         length    = fsp_pkg::LEN_NONE;
      endfunction

      function logic [31:0] accumulate(logic [31:0] acc, logic [7:0] c);
         logic [63:0] v;
         logic [63:0] top;
         top = (64'd1 << NUM_BITS) - 64'd1;
         v = {32'd0, acc} * 64'd10 + 64'(c) - 64'(fsp_pkg::CH_ZERO);
         if (v > top) begin
            return top[31:0];
         end
         return v[31:0];
      endfunction

      function void emit(logic [7:0] c);
         fsp_pkg::result_type r;
         r.conversion      = c;
         r.plus_flag       = flags.plus_flag;
         r.space_flag      = flags.space_flag;
         r.left_flag       = flags.left_flag;
         r.alternate_flag  = flags.alternate_flag;
         r.zero_pad_flag   = flags.zero_flag & ~flags.left_flag;
         r.field_width     = width_acc[15:0];
         r.has_precision   = dot_seen;
         r.precision_value = prec_acc[15:0];
         r.length_code     = length;
         expected_specs.push_back(r);
         clear_state();
      endfunction

      function void length_or_conv(logic [7:0] c);
         case (c)
            fsp_pkg::CH_L: begin
               length = fsp_pkg::LEN_L;
               phase  = fsp_pkg::PH_AFTER_L;
            end
            fsp_pkg::CH_H: begin
               length = fsp_pkg::LEN_H;
               phase  = fsp_pkg::PH_AFTER_H;
            end
            fsp_pkg::CH_J: begin
               length = fsp_pkg::LEN_J;
               phase  = fsp_pkg::PH_CONV;
            end
            fsp_pkg::CH_Z: begin
               length = fsp_pkg::LEN_Z;
               phase  = fsp_pkg::PH_CONV;
            end
            default: emit(c);
         endcase
      endfunction

      function void take_byte(logic [7:0] c);
         logic digit;
         digit = (c >= fsp_pkg::CH_ZERO) && (c <= fsp_pkg::CH_NINE);
         if (c == fsp_pkg::CH_NUL) begin
            emit(c);
            return;
         end
         case (phase)
            fsp_pkg::PH_WIDTH: begin
               if (digit) width_acc = accumulate(width_acc, c);
               else if (c == fsp_pkg::CH_DOT) begin
                  dot_seen = 1'b1;
                  prec_acc = '0;
                  phase    = fsp_pkg::PH_PREC;
               end else length_or_conv(c);
            end
            fsp_pkg::PH_PREC: begin
               if (digit) prec_acc = accumulate(prec_acc, c);
               else length_or_conv(c);
            end
            fsp_pkg::PH_AFTER_L: begin
               if (c == fsp_pkg::CH_L) begin
                  length = fsp_pkg::LEN_LL;
                  phase  = fsp_pkg::PH_CONV;
               end else emit(c);
            end
            fsp_pkg::PH_AFTER_H: begin
               if (c == fsp_pkg::CH_H) begin
                  length = fsp_pkg::LEN_HH;
                  phase  = fsp_pkg::PH_CONV;
               end else emit(c);
            end
            fsp_pkg::PH_CONV: emit(c);
            default: begin
               if (c == fsp_pkg::CH_PLUS) flags.plus_flag = 1'b1;
               else if (c == fsp_pkg::CH_SPACE) flags.space_flag = 1'b1;
               else if (c == fsp_pkg::CH_MINUS) flags.left_flag = 1'b1;
               else if (c == fsp_pkg::CH_HASH) flags.alternate_flag = 1'b1;
               else if (c == fsp_pkg::CH_ZERO) flags.zero_flag = 1'b1;
               else if (digit) begin
                  width_acc = accumulate('0, c);
                  phase     = fsp_pkg::PH_WIDTH;
               end else if (c == fsp_pkg::CH_DOT) begin
                  dot_seen = 1'b1;
                  prec_acc = '0;
                  phase    = fsp_pkg::PH_PREC;
               end else length_or_conv(c);
            end
         endcase
      endfunction

      function string describe(fsp_pkg::result_type r);
         return $sformatf("conv=%h +%b sp%b -%b #%b 0%b width=%0d prec=%b/%0d len=%0d",
                          r.conversion, r.plus_flag, r.space_flag, r.left_flag,
                          r.alternate_flag, r.zero_pad_flag, r.field_width,
                          r.has_precision, r.precision_value, r.length_code);
      endfunction

      function void report(string what);
         failures++;
         if (failures <= REPORT_LIMIT) $display("%0t: %s", $time, what);
      endfunction

      function void match_result(fsp_pkg::result_type got);
         fsp_pkg::result_type want;
         string               diff;
         if (expected_specs.size() == 0) begin
            report({"unexpected result: ", describe(got)});
            return;
         end
         want = expected_specs.pop_front();
         diff = "";
         if (got.conversion !== want.conversion) diff = {diff, " conversion"};
         if (got.plus_flag !== want.plus_flag) diff = {diff, " plus_flag"};
         if (got.space_flag !== want.space_flag) diff = {diff, " space_flag"};
         if (got.left_flag !== want.left_flag) diff = {diff, " left_flag"};
         if (got.alternate_flag !== want.alternate_flag) diff = {diff, " alternate_flag"};
         if (got.zero_pad_flag !== want.zero_pad_flag) diff = {diff, " zero_pad_flag"};
         if (got.field_width !== want.field_width) diff = {diff, " field_width"};
         if (got.has_precision !== want.has_precision) diff = {diff, " has_precision"};
         if (got.precision_value !== want.precision_value) diff = {diff, " precision_value"};
         if (got.length_code !== want.length_code) diff = {diff, " length_code"};
         if (diff != "") begin
            report({"mismatch in", diff, ": expected ", describe(want), ", got ", describe(got)});
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_ch = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_conversion;
   logic        rsp_plus_flag;
   logic        rsp_space_flag;
   logic        rsp_left_flag;
   logic        rsp_alternate_flag;
   logic        rsp_zero_pad_flag;
   logic [15:0] rsp_field_width;
   logic        rsp_has_precision;
   logic [15:0] rsp_precision_value;
   logic [2:0]  rsp_length_code;

   specifier_tracker tracker;
   int    send_idle_pct = 0;
   int    recv_idle_pct = 0;
   int    bytes_sent = 0;
   int    quiet_cycles = 0;
   string conv_chars = "diouxXfFeEgGaAcspn%";

   format_specifier_parser_top #(.NUMBER_BITS(NUM_BITS)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_ch(req_ch),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_conversion(rsp_conversion),
      .rsp_plus_flag(rsp_plus_flag),
      .rsp_space_flag(rsp_space_flag),
      .rsp_left_flag(rsp_left_flag),
      .rsp_alternate_flag(rsp_alternate_flag),
      .rsp_zero_pad_flag(rsp_zero_pad_flag),
      .rsp_field_width(rsp_field_width),
      .rsp_has_precision(rsp_has_precision),
      .rsp_precision_value(rsp_precision_value),
      .rsp_length_code(rsp_length_code)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      fsp_pkg::result_type seen;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_conversion, rsp_plus_flag, rsp_space_flag, rsp_left_flag,
                    rsp_alternate_flag, rsp_zero_pad_flag, rsp_field_width,
                    rsp_has_precision, rsp_precision_value, rsp_length_code};
            tracker.match_result(seen);
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_byte(b);
   endtask

   // sender holds off until every predicted specifier has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.expected_specs.size() != 0);
   endtask

   // mostly well-formed specifiers with random parts, some raw noise
   task automatic random_specifier();
      logic [7:0] s[$];
      int         k;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 4)) begin
            k = $urandom_range(0, 4);
            s.push_back(FLAG_CHARS[8*k +: 8]);
         end
         if ($urandom_range(0, 1) == 1) begin
            s.push_back(fsp_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
            k = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
            repeat (k) s.push_back(fsp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
         end
         if ($urandom_range(0, 2) == 0) begin
            s.push_back(fsp_pkg::CH_DOT);
            k = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 3);
            repeat (k) s.push_back(fsp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
         end
         case ($urandom_range(0, 11))
            0: s.push_back(fsp_pkg::CH_L);
            1: begin
               s.push_back(fsp_pkg::CH_L);
               s.push_back(fsp_pkg::CH_L);
            end
            2: s.push_back(fsp_pkg::CH_H);
            3: begin
               s.push_back(fsp_pkg::CH_H);
               s.push_back(fsp_pkg::CH_H);
            end
            4: s.push_back(fsp_pkg::CH_J);
            5: s.push_back(fsp_pkg::CH_Z);
            default: ;
         endcase
         k = $urandom_range(0, 9);
         if (k < 7) s.push_back(conv_chars[$urandom_range(0, conv_chars.len() - 1)]);
         else if (k < 9) s.push_back(8'($urandom_range(0, 255)));
         else s.push_back(fsp_pkg::CH_NUL);
      end
      foreach (s[i]) send_byte(s[i]);
      bytes_sent += s.size();
   endtask

   initial begin
      logic [7:0] directed[$];
      tracker = new();
      directed = '{fsp_pkg::CH_MINUS, fsp_pkg::CH_ZERO, fsp_pkg::CH_L, fsp_pkg::CH_L,
                   8'hff,
                   fsp_pkg::CH_PLUS, fsp_pkg::CH_SPACE, fsp_pkg::CH_HASH,
                   "9", "9", "9", "9", "9", fsp_pkg::CH_Z, "%",
                   fsp_pkg::CH_DOT, "7", "0", "0", "0", "0", fsp_pkg::CH_H,
                   fsp_pkg::CH_NUL,
                   fsp_pkg::CH_DOT, fsp_pkg::CH_DOT,
                   fsp_pkg::CH_L, "d",
                   fsp_pkg::CH_NUL};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_byte(directed[i]);
      wait_for_results();
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 26 : (p == 1) ? 77 : 0;
         recv_idle_pct = (p == 0) ? 77 : (p == 1) ? 26 : 0;
         bytes_sent = 0;
         while (bytes_sent < RANDOM_ITEMS / 3) random_specifier();
         wait_for_results();
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.expected_specs.size() != 0) begin
         tracker.report($sformatf("%0d expected results never arrived",
                                  tracker.expected_specs.size()));
      end
      if (tracker.failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
